### hdl/tbw_pkg.sv
// ----------------------------------------------------------------------------
// tbw_pkg: shared types and constants for the tetrahedron barycentric weights
// Holds the field widths, the wide arithmetic widths used by the datapath and
// the divider command and status types.
// ----------------------------------------------------------------------------
package tbw_pkg;

  localparam int unsigned CoordBits = 32;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned WeightBits = 32;

  // Edge components need one more bit than a coordinate.
  localparam int unsigned EdgeBits = CoordBits + 1;
  // Minor (2x2 determinant) and full 3x3 determinant widths.
  localparam int unsigned MinorBits = 2 * EdgeBits + 1;
  localparam int unsigned DetBits   = 3 * EdgeBits + 3;
  // Numerator after the fixed-point scale.
  localparam int unsigned NumBits   = DetBits + FracBits;
  // Accumulator for the sum of the three quotients.
  localparam int unsigned AccBits   = NumBits + 3;

  // Magnitude multiplier chunk width (one partial product per cycle).
  localparam int unsigned MulBits = 32;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [EdgeBits-1:0]  edge_t;
  typedef logic signed [DetBits-1:0]   det_t;
  typedef logic signed [NumBits-1:0]   num_t;

  // Divider command and status between the top level and the divider.
  typedef struct packed {
    logic start;
    logic neg;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### hdl/tetrahedron_barycentric_weights.sv
// ----------------------------------------------------------------------------
// tetrahedron_barycentric_weights: barycentric weights of a point in a
// tetrahedron by Cramer's rule, signed Q16.16
// ----------------------------------------------------------------------------
// Load words (mode 0) store one vertex and produce no result. A query word
// (mode 1) forms edge vectors from vertex 0, then computes the main
// determinant and the three column-replaced determinants on one shared
// sequential multiplier. Each determinant takes nine products, and each
// product is built from eight 32x32 partial products. The three quotients
// then run on a one-bit-per-cycle restoring divider, 118 bits wide. A
// degenerate tetrahedron (zero main determinant) skips the remaining
// determinants and the divisions, and returns (1.0, 0, 0, 0) with degenerate
// set. The block holds stall_o high while a query is at work and while a
// result waits, so the next word is taken no earlier than the cycle after
// the result leaves.
// Querying before all four vertices are loaded gives undefined weights.
// ----------------------------------------------------------------------------
module tetrahedron_barycentric_weights (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic        mode_i,
  input  logic [1:0]  vertex_index_i,
  input  logic signed [tbw_pkg::CoordBits-1:0] coord_x_i,
  input  logic signed [tbw_pkg::CoordBits-1:0] coord_y_i,
  input  logic signed [tbw_pkg::CoordBits-1:0] coord_z_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic signed [31:0] weight_a_o,
  output logic signed [31:0] weight_b_o,
  output logic signed [31:0] weight_c_o,
  output logic signed [31:0] weight_d_o,
  output logic        degenerate_o
);

  localparam int unsigned CB  = tbw_pkg::CoordBits;
  localparam int unsigned EB  = tbw_pkg::EdgeBits;
  localparam int unsigned DB  = tbw_pkg::DetBits;
  localparam int unsigned NB  = tbw_pkg::NumBits;
  localparam int unsigned AB  = tbw_pkg::AccBits;
  localparam int unsigned FB  = tbw_pkg::FracBits;

  // Sequencer states.
  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StEdge  = 3'd1;
  localparam logic [2:0] StMul   = 3'd2;
  localparam logic [2:0] StWait  = 3'd3;
  localparam logic [2:0] StDiv   = 3'd4;
  localparam logic [2:0] StDivW  = 3'd5;
  localparam logic [2:0] StOut   = 3'd6;

  logic [2:0] state_q, state_d;

  // Vertex stores.
  logic signed [CB-1:0] vx_q [4];
  logic signed [CB-1:0] vy_q [4];
  logic signed [CB-1:0] vz_q [4];

  // Edge matrix: rows x,y,z; columns e1,e2,e3,r.
  logic signed [EB-1:0] m_q [3][4];
  logic signed [CB-1:0] px_q, py_q, pz_q;

  // Determinant sequencing: det index 0 = main, 1..3 = column replaced.
  logic [1:0] det_q;
  logic [3:0] prod_q;     // product counter 0..8 within one determinant
  logic signed [AB-1:0] minor_q;
  logic signed [AB-1:0] detacc_q;
  logic signed [DB-1:0] dmain_q;
  logic signed [DB-1:0] dcol_q [3];
  logic [1:0] qi_q;
  logic signed [AB-1:0] qsum_q;
  logic signed [NB:0]   quo_q [3];
  logic degen_q;
  logic valid_q;

  logic accept;
  assign accept = valid_i && !stall_o;
  assign stall_o = (state_q != StIdle) || valid_q;

  // Column for matrix entry of a determinant with one column replaced.
  function automatic logic [1:0] colmap(input logic [1:0] c, input logic [1:0] d);
    logic [1:0] r;
    r = (d != 2'd0 && c == d - 2'd1) ? 2'd3 : c;
    return r;
  endfunction

  // Product schedule per 3x3 term t (0..2): minor built from rows 1,2,
  // columns a,b; then multiplied by row 0 column t.
  // prod 3t: m1a*m2b ; 3t+1: m1b*m2a (subtract) ; 3t+2: m0t*minor.
  logic [1:0] term;
  logic [1:0] sub;
  logic [1:0] ca, cb2;
  logic signed [NB-1:0] mul_a;
  logic signed [EB-1:0] mul_b;
  logic mul_start, mul_done;
  logic signed [AB-1:0] mul_p;

  always_comb begin
    term = 2'd0;
    sub  = 2'd0;
    case (prod_q)
      4'd0, 4'd1, 4'd2: begin term = 2'd0; sub = 2'(prod_q); end
      4'd3, 4'd4, 4'd5: begin term = 2'd1; sub = 2'(prod_q - 4'd3); end
      4'd6, 4'd7, 4'd8: begin term = 2'd2; sub = 2'(prod_q - 4'd6); end
      default: begin term = 2'd0; sub = 2'd0; end
    endcase
    ca  = (term == 2'd0) ? 2'd1 : 2'd0;
    cb2 = (term == 2'd2) ? 2'd1 : 2'd2;
    case (sub)
      2'd0: begin
        mul_a = NB'(m_q[1][colmap(ca, det_q)]);
        mul_b = m_q[2][colmap(cb2, det_q)];
      end
      2'd1: begin
        mul_a = NB'(m_q[1][colmap(cb2, det_q)]);
        mul_b = m_q[2][colmap(ca, det_q)];
      end
      default: begin
        mul_a = NB'(minor_q);
        mul_b = m_q[0][colmap(term, det_q)];
      end
    endcase
  end

  tbw_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // Divider.
  tbw_pkg::div_ctrl_t div_ctrl;
  tbw_pkg::div_stat_t div_stat;
  logic signed [NB-1:0] numer;
  logic [NB-1:0] num_mag;
  logic [DB-1:0] den_mag;
  logic signed [NB:0] quo;

  assign numer   = NB'(dcol_q[qi_q]) <<< FB;
  assign num_mag = numer[NB-1] ? NB'(-numer) : NB'(numer);
  assign den_mag = dmain_q[DB-1] ? DB'(-dmain_q) : DB'(dmain_q);
  assign div_ctrl.start = (state_q == StDiv);
  assign div_ctrl.neg   = numer[NB-1] ^ dmain_q[DB-1];

  tbw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (num_mag),
    .den_i  (den_mag),
    .stat_o (div_stat),
    .quo_o  (quo)
  );

  assign mul_start = (state_q == StMul);

  // Saturate a wide signed value to the weight width.
  function automatic logic signed [31:0] sat(input logic signed [AB-1:0] v);
    logic signed [31:0] r;
    if (v > AB'(signed'(32'sh7fffffff)))       r = 32'sh7fffffff;
    else if (v < AB'(signed'(-32'sh80000000))) r = 32'sh80000000;
    else                                       r = v[31:0];
    return r;
  endfunction

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (accept && mode_i) state_d = StEdge;
      StEdge: state_d = StMul;
      StMul:  state_d = StWait;
      StWait: begin
        if (mul_done) begin
          if (prod_q != 4'd8) state_d = StMul;
          else if (det_q == 2'd0 && (detacc_q + mul_p) == '0) state_d = StOut;
          else if (det_q != 2'd3) state_d = StMul;
          else state_d = StDiv;
        end
      end
      StDiv:  state_d = StDivW;
      StDivW: begin
        if (div_stat.done) state_d = (qi_q == 2'd2) ? StOut : StDiv;
      end
      StOut:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= 1'b0;
      det_q   <= '0;
      prod_q  <= '0;
      qi_q    <= '0;
    end else begin
      state_q <= state_d;
      if (valid_q && !stall_i) valid_q <= 1'b0;
      if (state_q == StOut) valid_q <= 1'b1;
      if (state_q == StEdge) begin
        det_q  <= '0;
        prod_q <= '0;
        qi_q   <= '0;
      end
      if (state_q == StWait && mul_done) begin
        if (prod_q == 4'd8) begin
          prod_q <= '0;
          det_q  <= det_q + 2'd1;
        end else begin
          prod_q <= prod_q + 4'd1;
        end
      end
      if (state_q == StDivW && div_stat.done) qi_q <= qi_q + 2'd1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept && !mode_i) begin
      vx_q[vertex_index_i] <= coord_x_i;
      vy_q[vertex_index_i] <= coord_y_i;
      vz_q[vertex_index_i] <= coord_z_i;
    end
    if (accept && mode_i) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
      pz_q <= coord_z_i;
    end
    if (state_q == StEdge) begin
      for (int k = 0; k < 3; k++) begin
        m_q[0][k] <= EB'(vx_q[k+1]) - EB'(vx_q[0]);
        m_q[1][k] <= EB'(vy_q[k+1]) - EB'(vy_q[0]);
        m_q[2][k] <= EB'(vz_q[k+1]) - EB'(vz_q[0]);
      end
      m_q[0][3] <= EB'(px_q) - EB'(vx_q[0]);
      m_q[1][3] <= EB'(py_q) - EB'(vy_q[0]);
      m_q[2][3] <= EB'(pz_q) - EB'(vz_q[0]);
      detacc_q  <= '0;
      qsum_q    <= '0;
      degen_q   <= 1'b0;
    end
    if (state_q == StWait && mul_done) begin
      case (sub)
        2'd0: minor_q <= mul_p;
        2'd1: minor_q <= minor_q - mul_p;
        default: begin
          if (prod_q == 4'd8) begin
            detacc_q <= '0;
            if (det_q == 2'd0) begin
              dmain_q <= DB'(detacc_q + mul_p);
              degen_q <= (detacc_q + mul_p) == '0;
            end else begin
              dcol_q[det_q - 2'd1] <= DB'(detacc_q + mul_p);
            end
          end else if (term == 2'd1) begin
            detacc_q <= detacc_q - mul_p;
          end else begin
            detacc_q <= detacc_q + mul_p;
          end
        end
      endcase
    end
    if (state_q == StDivW && div_stat.done) begin
      quo_q[qi_q] <= quo;
      qsum_q      <= qsum_q + AB'(quo);
    end
    if (state_q == StOut) begin
      degenerate_o <= degen_q;
      if (degen_q) begin
        weight_a_o <= 32'sd1 <<< FB;
        weight_b_o <= '0;
        weight_c_o <= '0;
        weight_d_o <= '0;
      end else begin
        weight_a_o <= sat((AB'(1) <<< FB) - qsum_q);
        weight_b_o <= sat(AB'(quo_q[0]));
        weight_c_o <= sat(AB'(quo_q[1]));
        weight_d_o <= sat(AB'(quo_q[2]));
      end
    end
  end

  assign valid_o = valid_q;

endmodule

### hdl/tbw_mul.sv
// ----------------------------------------------------------------------------
// tbw_mul: shared sequential signed multiplier
// Multiplies a signed wide value by a signed edge value through 32x32
// partial products, one per cycle, accumulating into a registered product.
// ----------------------------------------------------------------------------
module tbw_mul (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [tbw_pkg::NumBits-1:0]   a_i,
  input  logic signed [tbw_pkg::EdgeBits-1:0]  b_i,
  output logic                                 done_o,
  output logic signed [tbw_pkg::AccBits-1:0]   p_o
);

  localparam int unsigned ABits   = tbw_pkg::NumBits;
  localparam int unsigned BBits   = tbw_pkg::EdgeBits;
  localparam int unsigned MB      = tbw_pkg::MulBits;
  localparam int unsigned AChunks = (ABits + MB - 1) / MB;
  localparam int unsigned BChunks = (BBits + MB - 1) / MB;
  localparam int unsigned Steps   = AChunks * BChunks;
  localparam int unsigned StBits  = $clog2(Steps + 1);
  localparam int unsigned AW      = AChunks * MB;
  localparam int unsigned BW      = BChunks * MB;
  localparam int unsigned PW      = AW + BW;
  localparam int unsigned AIdxBits = (AChunks > 1) ? $clog2(AChunks) : 1;
  localparam int unsigned BIdxBits = (BChunks > 1) ? $clog2(BChunks) : 1;

  logic [AW-1:0]     ua_q;
  logic [BW-1:0]     ub_q;
  logic              neg_q;
  logic [PW-1:0]     acc_q;
  logic [StBits-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  logic [ABits-1:0]  abs_a;
  logic [BBits-1:0]  abs_b;
  logic [AIdxBits-1:0] ai;
  logic [BIdxBits-1:0] bi;
  logic [MB-1:0]     pa;
  logic [MB-1:0]     pb;
  logic [2*MB-1:0]   pp;
  logic [PW-1:0]     pp_sh;
  logic [PW-1:0]     prod;

  assign abs_a = a_i[ABits-1] ? ABits'(-a_i) : ABits'(a_i);
  assign abs_b = b_i[BBits-1] ? BBits'(-b_i) : BBits'(b_i);

  assign ai = AIdxBits'(32'(step_q) % AChunks);
  assign bi = BIdxBits'(32'(step_q) / AChunks);
  assign pa = ua_q[ai*MB +: MB];
  assign pb = ub_q[bi*MB +: MB];
  assign pp = pa * pb;
  assign pp_sh = PW'(pp) << (32'(ai) * MB + 32'(bi) * MB);
  assign prod = neg_q ? -acc_q : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == StBits'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= AW'(abs_a);
      ub_q  <= BW'(abs_b);
      neg_q <= a_i[ABits-1] ^ b_i[BBits-1];
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
  end

  assign done_o = done_q;
  assign p_o    = tbw_pkg::AccBits'(signed'(prod));

endmodule

### hdl/tbw_div.sv
// ----------------------------------------------------------------------------
// tbw_div: restoring divider, one quotient bit per cycle
// Divides magnitudes and applies the sign at the end, truncating to zero.
// ----------------------------------------------------------------------------
module tbw_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  tbw_pkg::div_ctrl_t                 ctrl_i,
  input  logic        [tbw_pkg::NumBits-1:0] num_i,
  input  logic        [tbw_pkg::DetBits-1:0] den_i,
  output tbw_pkg::div_stat_t                 stat_o,
  output logic signed [tbw_pkg::NumBits:0]   quo_o
);

  localparam int unsigned NB = tbw_pkg::NumBits;
  localparam int unsigned DB = tbw_pkg::DetBits;
  localparam int unsigned CB = $clog2(NB + 1);

  logic [NB-1:0] n_q;
  logic [NB-1:0] q_q;
  logic [DB:0]   r_q;
  logic [DB-1:0] d_q;
  logic          neg_q;
  logic [CB-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  logic [DB:0]   shr;
  logic [DB+1:0] diff;

  assign shr  = {r_q[DB-1:0], n_q[NB-1]};
  assign diff = {1'b0, shr} - {2'b00, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CB'(NB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CB'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      n_q   <= num_i;
      d_q   <= den_i;
      r_q   <= '0;
      q_q   <= '0;
      neg_q <= ctrl_i.neg;
    end else if (busy_q) begin
      n_q <= n_q << 1;
      if (!diff[DB+1]) begin
        r_q <= diff[DB:0];
        q_q <= {q_q[NB-2:0], 1'b1};
      end else begin
        r_q <= shr;
        q_q <= {q_q[NB-2:0], 1'b0};
      end
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quo_o = neg_q ? -signed'({1'b0, q_q}) : signed'({1'b0, q_q});

endmodule

### hdl/tbw_checker.sv
// ----------------------------------------------------------------------------
// tbw_checker: port-level checks for the barycentric weights block
// ----------------------------------------------------------------------------
module tbw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        valid_i,
  input logic        stall_o,
  input logic        valid_o,
  input logic        stall_i,
  input logic [31:0] weight_a_o,
  input logic        degenerate_o,
  input logic [31:0] weight_b_o
);

  // A held result stays valid and keeps its weight_a value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(weight_a_o))
    else $error("held result changed");

  // A waiting result blocks new input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o)
    else $error("input open while result waits");

  // A degenerate result has weight_a of 1.0 and weight_b of 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_o |-> weight_a_o == 32'h00010000 && weight_b_o == '0)
    else $error("bad degenerate weights");

  // A retired result reopens the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(valid_o) |-> !stall_o)
    else $error("input not reopened after result");

endmodule

bind tetrahedron_barycentric_weights tbw_checker u_tbw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .valid_i      (valid_i),
  .stall_o      (stall_o),
  .valid_o      (valid_o),
  .stall_i      (stall_i),
  .weight_a_o   (weight_a_o),
  .degenerate_o (degenerate_o),
  .weight_b_o   (weight_b_o)
);

### dv/barycentric_checker.sv
// ----------------------------------------------------------------------------
// barycentric_checker: weight predictor and scoreboard
// Watches both channels of the tetrahedron weights block, keeps its own copy
// of the vertex store, predicts the weights of every accepted query and
// checks each delivered result against the oldest prediction.
// ----------------------------------------------------------------------------
module barycentric_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic             stall_o,
  input  logic             mode_i,
  input  logic [1:0]       vertex_index_i,
  input  tbw_pkg::coord_t  coord_x_i,
  input  tbw_pkg::coord_t  coord_y_i,
  input  tbw_pkg::coord_t  coord_z_i,
  input  logic             valid_o,
  input  logic             stall_i,
  input  logic signed [31:0] weight_a_o,
  input  logic signed [31:0] weight_b_o,
  input  logic signed [31:0] weight_c_o,
  input  logic signed [31:0] weight_d_o,
  input  logic             degenerate_o,
  output int               error_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ModeLoad = 1'b0;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic signed [31:0] wa;
    logic signed [31:0] wb;
    logic signed [31:0] wc;
    logic signed [31:0] wd;
    logic               degen;
  } weights_t;

  localparam wide_t WMax = wide_t'(64'sd2147483647);
  localparam wide_t WMin = -wide_t'(64'sd2147483648);

  tbw_pkg::coord_t vx [4];
  tbw_pkg::coord_t vy [4];
  tbw_pkg::coord_t vz [4];
  weights_t expected_weights [$];

  function automatic wide_t det3(wide_t m00, wide_t m01, wide_t m02,
                                 wide_t m10, wide_t m11, wide_t m12,
                                 wide_t m20, wide_t m21, wide_t m22);
    return m00 * (m11 * m22 - m12 * m21)
         - m01 * (m10 * m22 - m12 * m20)
         + m02 * (m10 * m21 - m11 * m20);
  endfunction

  function automatic logic signed [31:0] sat32(wide_t v);
    if (v > WMax) return 32'sh7fffffff;
    if (v < WMin) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic weights_t compute_weights(tbw_pkg::coord_t px, tbw_pkg::coord_t py,
                                               tbw_pkg::coord_t pz);
    wide_t    ex [3];
    wide_t    ey [3];
    wide_t    ez [3];
    wide_t    rx, ry, rz, d, one, wa;
    wide_t    q [3];
    weights_t w;
    for (int k = 0; k < 3; k++) begin
      ex[k] = wide_t'(vx[k+1]) - wide_t'(vx[0]);
      ey[k] = wide_t'(vy[k+1]) - wide_t'(vy[0]);
      ez[k] = wide_t'(vz[k+1]) - wide_t'(vz[0]);
    end
    rx  = wide_t'(px) - wide_t'(vx[0]);
    ry  = wide_t'(py) - wide_t'(vy[0]);
    rz  = wide_t'(pz) - wide_t'(vz[0]);
    one = wide_t'(1) <<< tbw_pkg::FracBits;
    d   = det3(ex[0], ex[1], ex[2], ey[0], ey[1], ey[2], ez[0], ez[1], ez[2]);
    if (d == 0) begin
      w = '{wa: sat32(one), wb: '0, wc: '0, wd: '0, degen: 1'b1};
      return w;
    end
    // Replace one column at a time by R; signed divide truncates toward zero.
    q[0] = (det3(rx, ex[1], ex[2], ry, ey[1], ey[2], rz, ez[1], ez[2])
            <<< tbw_pkg::FracBits) / d;
    q[1] = (det3(ex[0], rx, ex[2], ey[0], ry, ey[2], ez[0], rz, ez[2])
            <<< tbw_pkg::FracBits) / d;
    q[2] = (det3(ex[0], ex[1], rx, ey[0], ey[1], ry, ez[0], ez[1], rz)
            <<< tbw_pkg::FracBits) / d;
    wa = one - q[0] - q[1] - q[2];
    w  = '{wa: sat32(wa), wb: sat32(q[0]), wc: sat32(q[1]), wd: sat32(q[2]), degen: 1'b0};
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    weights_t got, want;
    if (!rst_ni) begin
      error_count_o = 0;
      pending_o     = 0;
      for (int k = 0; k < 4; k++) begin
        vx[k] = '0;
        vy[k] = '0;
        vz[k] = '0;
      end
    end else begin
      // Retire a result before taking the next word.
      if (valid_o && !stall_i) begin
        got = '{wa: weight_a_o, wb: weight_b_o, wc: weight_c_o, wd: weight_d_o,
                degen: degenerate_o};
        if (expected_weights.size() == 0) begin
          $display("%t: unexpected result a=%h b=%h c=%h d=%h degenerate=%b", $realtime,
                   got.wa, got.wb, got.wc, got.wd, got.degen);
          error_count_o++;
        end else begin
          want = expected_weights.pop_front();
          if (got !== want) begin
            $display("%t: weight mismatch expected a=%h b=%h c=%h d=%h degenerate=%b",
                     $realtime, want.wa, want.wb, want.wc, want.wd, want.degen);
            $display("%t:                 actual   a=%h b=%h c=%h d=%h degenerate=%b",
                     $realtime, got.wa, got.wb, got.wc, got.wd, got.degen);
            error_count_o++;
          end
        end
      end
      if (valid_i && !stall_o) begin
        if (mode_i == ModeLoad) begin
          vx[vertex_index_i] = coord_x_i;
          vy[vertex_index_i] = coord_y_i;
          vz[vertex_index_i] = coord_z_i;
        end else begin
          expected_weights.push_back(compute_weights(coord_x_i, coord_y_i, coord_z_i));
        end
      end
      pending_o = expected_weights.size();
    end
  end

endmodule

### dv/tetrahedron_barycentric_weights_tb.sv
// ----------------------------------------------------------------------------
// tetrahedron_barycentric_weights_tb: top of the weights block testbench
// Drives load and query words with random gaps, stalls the result side at
// random (once for a long stretch), and leaves prediction and checking to
// barycentric_checker. Prints the verdict once all results are in.
// ----------------------------------------------------------------------------
module tetrahedron_barycentric_weights_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ModeLoad  = 1'b0;
  localparam logic ModeQuery = 1'b1;
  localparam int   RandomWords = 1200;
  localparam int   IdleLimit   = 20000;
  localparam int   HoldCycles  = 3000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            valid_i = 1'b0;
  logic            stall_o;
  logic            mode_i = ModeLoad;
  logic [1:0]      vertex_index_i = '0;
  tbw_pkg::coord_t coord_x_i = '0;
  tbw_pkg::coord_t coord_y_i = '0;
  tbw_pkg::coord_t coord_z_i = '0;
  logic            valid_o;
  logic            stall_i = 1'b0;
  logic signed [31:0] weight_a_o, weight_b_o, weight_c_o, weight_d_o;
  logic            degenerate_o;
  int              error_count, pending;
  int              sent;
  bit              hold_long = 1'b0;
  int              idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  tetrahedron_barycentric_weights uut (.*);

  barycentric_checker checker_i (
    .clk_i, .rst_ni, .valid_i, .stall_o, .mode_i, .vertex_index_i,
    .coord_x_i, .coord_y_i, .coord_z_i, .valid_o, .stall_i,
    .weight_a_o, .weight_b_o, .weight_c_o, .weight_d_o, .degenerate_o,
    .error_count_o(error_count), .pending_o(pending)
  );

  // Gap before a word: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Coordinate mix: small values near the origin, full-range values, extremes.
  function automatic tbw_pkg::coord_t pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return tbw_pkg::coord_t'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    end
    if (r < 90) return tbw_pkg::coord_t'($urandom());
    if (r < 95) return 32'sh7fffffff;
    return 32'sh80000000;
  endfunction

  // Offer one word and hold it until accepted; leave valid up for the next.
  task automatic send_word(logic mode, logic [1:0] idx, tbw_pkg::coord_t x,
                           tbw_pkg::coord_t y, tbw_pkg::coord_t z, int gap);
    repeat (gap) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i        <= 1'b1;
    mode_i         <= mode;
    vertex_index_i <= idx;
    coord_x_i      <= x;
    coord_y_i      <= y;
    coord_z_i      <= z;
    do @(posedge clk_i); while (stall_o);
    sent++;
  endtask

  task automatic load_tetra(tbw_pkg::coord_t ax, tbw_pkg::coord_t ay, tbw_pkg::coord_t az,
                            tbw_pkg::coord_t bx, tbw_pkg::coord_t by, tbw_pkg::coord_t bz,
                            tbw_pkg::coord_t cx, tbw_pkg::coord_t cy, tbw_pkg::coord_t cz,
                            tbw_pkg::coord_t dx, tbw_pkg::coord_t dy, tbw_pkg::coord_t dz);
    send_word(ModeLoad, 2'd0, ax, ay, az, pick_gap());
    send_word(ModeLoad, 2'd1, bx, by, bz, pick_gap());
    send_word(ModeLoad, 2'd2, cx, cy, cz, pick_gap());
    send_word(ModeLoad, 2'd3, dx, dy, dz, pick_gap());
  endtask

  // Result side: bursts of ready and stalled cycles, plus one long hold-off.
  initial begin
    int len;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_long = 1'b0;
      end
      len = $urandom_range(1, 20);
      repeat (len) begin
        stall_i <= 1'b0;
        @(posedge clk_i);
      end
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 300) : $urandom_range(0, 4);
      repeat (len) begin
        stall_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: abort when neither channel moves a word for too long.
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    tbw_pkg::coord_t one;
    tbw_pkg::coord_t vx, vy, vz;
    int              queries;
    sent = 0;
    one  = 32'sh0001_0000;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Unit tetrahedron: centroid, a vertex, an outside point.
    load_tetra(0, 0, 0, one, 0, 0, 0, one, 0, 0, 0, one);
    send_word(ModeQuery, 2'd3, 32'sh4000, 32'sh4000, 32'sh4000, 0);
    send_word(ModeQuery, 2'd0, one, 0, 0, 0);
    send_word(ModeQuery, 2'd1, -one, 3 * one, -2 * one, 1);
    // Tiny volume with extreme points: every weight saturates.
    load_tetra(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 1);
    send_word(ModeQuery, 2'd2, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_word(ModeQuery, 2'd1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    // Vertices at the coordinate extremes.
    load_tetra(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
               32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
               32'sh80000000, 32'sh7fffffff);
    send_word(ModeQuery, 2'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0);
    send_word(ModeQuery, 2'd3, 0, 0, 0, 0);
    // Flat tetrahedron: all vertices coincide, then a coplanar one.
    load_tetra(one, one, one, one, one, one, one, one, one, one, one, one);
    send_word(ModeQuery, 2'd0, 0, 0, 0, 0);
    send_word(ModeLoad, 2'd3, 2 * one, 2 * one, one, 0);
    send_word(ModeQuery, 2'd1, one, 0, one, 0);

    // Fill the block while results are held off.
    hold_long = 1'b1;
    load_tetra(0, 0, 0, 2 * one, 0, 0, 0, 2 * one, 0, 0, 0, 2 * one);
    repeat (4) send_word(ModeQuery, 2'($urandom()), pick_coord(), pick_coord(),
                         pick_coord(), 0);

    // Random tetrahedra, some of them flat, each followed by a few queries.
    while (sent < RandomWords + 25) begin
      load_tetra(pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                 pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                 pick_coord(), pick_coord());
      if ($urandom_range(0, 9) == 0) begin
        // Collapse one vertex onto another to make the volume vanish.
        vx = pick_coord();
        vy = pick_coord();
        vz = pick_coord();
        send_word(ModeLoad, 2'd1, vx, vy, vz, pick_gap());
        send_word(ModeLoad, 2'($urandom_range(2, 3)), vx, vy, vz, pick_gap());
      end
      queries = $urandom_range(1, 3);
      repeat (queries) begin
        if ($urandom_range(0, 9) == 0) begin
          // Reload a single vertex with random data between queries.
          send_word(ModeLoad, 2'($urandom()), pick_coord(), pick_coord(), pick_coord(),
                    pick_gap());
        end
        send_word(ModeQuery, 2'($urandom()), pick_coord(), pick_coord(), pick_coord(),
                  pick_gap());
      end
    end
    valid_i <= 1'b0;

    // Let the checker register the last accepted word before polling.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
